@@ src/hds_pkg.sv @@
package hds_pkg;

    localparam int GRID_SIDE_MAX_DEF = 128;
    localparam int VALUE_BITS_DEF    = 32;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int INNER_W   = 7;
    localparam int ITER_W    = 20;
    localparam int K_W       = 15;
    localparam int EDGE_W    = 32;
    localparam int IDX_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int CELL_W    = 32;

    localparam logic [INNER_W-1:0] INNER_RST = 7'd100;
    localparam logic [ITER_W-1:0]  ITER_RST  = 20'd10000;
    localparam logic [K_W-1:0]     K_RST     = 15'd16384;
    localparam logic [EDGE_W-1:0]  TOP_RST   = 32'd655360;
    localparam logic [EDGE_W-1:0]  BOT_RST   = 32'd2621440;
    localparam logic [EDGE_W-1:0]  LEFT_RST  = 32'd1310720;
    localparam logic [EDGE_W-1:0]  RIGHT_RST = 32'd1966080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER  = 3'd0,
        CFG_ITER   = 3'd1,
        CFG_K      = 3'd2,
        CFG_TOP    = 3'd3,
        CFG_BOTTOM = 3'd4,
        CFG_LEFT   = 3'd5,
        CFG_RIGHT  = 3'd6
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        STS_RUN_DONE = 2'd0,
        STS_READ_OK  = 2'd1,
        STS_READ_OOR = 2'd2
    } t_status;

    typedef enum logic {
        FN_RUN  = 1'b0,
        FN_READ = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SWEEP,
        S_DRAIN,
        S_RDADDR,
        S_RESP
    } t_state;

endpackage

@@ src/hds_cell.sv @@
module hds_cell import hds_pkg::*; #(
    parameter int WIDTH = VALUE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ src/hds_bank.sv @@
module hds_bank import hds_pkg::*; #(
    parameter int WIDTH = VALUE_BITS_DEF,
    parameter int DEPTH = GRID_SIDE_MAX_DEF * GRID_SIDE_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/heat_diffusion_stencil_2d_top.sv @@
// Channel   Direction  Ports                                        Handshake
// request   in         i_func, i_row_index, i_col_index             i_start & !o_busy
// result    out        o_status, o_cell_value                       o_valid, one cycle
// config    in         i_cfg_addr, i_cfg_wdata                      i_cfg_we
//
// A read passes through S_RDADDR, where the bank read is registered, to S_RESP.
// A run lays out the grid in S_INIT, then sweeps and drains once per time step, then
// gives its result in S_RESP: during each sweep the grid streams from one bank at one
// cell a cycle through a shift line of 2*GRID_SIDE_MAX+1 cells, and the run ends early
// once a step changes nothing.
// Reset is synchronous; the banks are not cleared, only the control and configuration registers.
// The result strobe lasts one cycle and cannot be held off.
module heat_diffusion_stencil_2d_top import hds_pkg::*; #(
    parameter int GRID_SIDE_MAX = GRID_SIDE_MAX_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_func,
    input  logic [IDX_W-1:0]     i_row_index,
    input  logic [IDX_W-1:0]     i_col_index,
    output logic                 o_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [CELL_W-1:0]    o_cell_value,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int GM     = GRID_SIDE_MAX;
    localparam int VB     = VALUE_BITS;
    localparam int DEPTH  = GM * GM;
    localparam int AW     = $clog2(DEPTH);
    localparam int RW     = $clog2(GM);
    localparam int SW     = $clog2(GM + 1);
    localparam int NTAP   = 2 * GM + 1;
    localparam int LAP_W  = VB + 3;
    localparam int PROD_W = LAP_W + 16;

    localparam logic signed [127:0] V_MAX = (128'sd1 <<< (VB - 1)) - 128'sd1;
    localparam logic signed [127:0] V_MIN = -V_MAX - 128'sd1;
    localparam logic signed [127:0] P_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] P_MIN = -P_MAX;

    function automatic logic [AW-1:0] f_addr(input int r, input int c);
        return AW'(r * GM + c);
    endfunction

    function automatic logic [VB-1:0] f_edge(input logic [EDGE_W-1:0] e);
        logic signed [127:0] x;
        x = 128'($signed(e));
        if (x > V_MAX) x = V_MAX;
        if (x < V_MIN) x = V_MIN;
        return x[VB-1:0];
    endfunction

    t_state r_state, n_state;

    logic [INNER_W-1:0] r_cfg_inner;
    logic [ITER_W-1:0]  r_cfg_iter;
    logic [K_W-1:0]     r_cfg_k;
    logic [EDGE_W-1:0]  r_cfg_top, r_cfg_bot, r_cfg_left, r_cfg_right;

    logic             r_cur_bank, r_grid_valid, r_src, r_changed;
    logic [RW-1:0]    r_row, r_col;
    logic [ITER_W-1:0] r_iter;
    t_status          r_status;
    logic [AW-1:0]    r_rd_addr;

    logic             r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic [RW-1:0]    r_s1_row, r_s1_col, r_s2_row, r_s2_col;
    logic signed [LAP_W-1:0]  r_s3_lap;
    logic [VB-1:0]    r_s3_old, r_s4_old, r_s4_dold;
    logic [AW-1:0]    r_s3_addr, r_s4_addr;
    logic signed [PROD_W-1:0] r_s4_prod;

    logic [SW-1:0]    side;
    int               side_i, row_i, col_i, r2_i, c2_i;
    logic             init_last, sweep_last, pipe_empty, last_step, interior;
    logic [VB-1:0]    init_val, nv;
    logic [VB-1:0]    rdata [0:1];
    logic [VB-1:0]    src_rdata;
    logic [VB-1:0]    tap [0:NTAP-1];
    logic [VB-1:0]    chain_in [0:NTAP-1];
    logic [AW-1:0]    sweep_addr, dst_addr;
    logic signed [LAP_W-1:0] lap_c;
    logic signed [127:0] p_sat, sum_w, ov;
    logic             accept, s0_vld;

    // grid side, inner size clipped to what the banks hold
    always_comb begin
        if (32'(r_cfg_inner) > 32'(GM - 2)) begin
            side = SW'(GM);
        end else begin
            side = SW'(32'(r_cfg_inner) + 32'd2);
        end
    end

    assign side_i     = int'(side);
    assign row_i      = int'(r_row);
    assign col_i      = int'(r_col);
    assign r2_i       = int'(r_s2_row);
    assign c2_i       = int'(r_s2_col);
    assign init_last  = (row_i == side_i - 1) && (col_i == side_i - 1);
    assign sweep_last = (row_i == side_i - 1) && (col_i == GM - 1);
    assign pipe_empty = !r_s1_vld && !r_s2_vld && !r_s3_vld && !r_s4_vld;
    assign last_step  = !r_changed || (r_iter == r_cfg_iter - ITER_W'(1));
    assign accept     = i_start && !o_busy;
    assign s0_vld     = (r_state == S_SWEEP);

    always_comb begin
        if (row_i == 0) begin
            init_val = f_edge(r_cfg_top);
        end else if (row_i == side_i - 1) begin
            init_val = f_edge(r_cfg_bot);
        end else if (col_i == 0) begin
            init_val = f_edge(r_cfg_left);
        end else if (col_i == side_i - 1) begin
            init_val = f_edge(r_cfg_right);
        end else begin
            init_val = '0;
        end
    end

    // ---------------- banks
    assign sweep_addr = f_addr(row_i, col_i);
    assign dst_addr   = f_addr(r2_i - 1, c2_i);

    for (genvar b = 0; b < 2; b++) begin : g_bank
        logic          we;
        logic [AW-1:0] waddr, raddr;
        logic [VB-1:0] wdata;

        always_comb begin
            if (r_state == S_INIT) begin
                we    = 1'b1;
                waddr = sweep_addr;
                wdata = init_val;
            end else begin
                we    = r_s4_vld && (r_src != 1'(b));
                waddr = r_s4_addr;
                wdata = nv;
            end
            if (r_state == S_RDADDR) begin
                raddr = r_rd_addr;
            end else if (r_src == 1'(b)) begin
                raddr = sweep_addr;
            end else begin
                raddr = dst_addr;
            end
        end

        hds_bank #(.WIDTH(VB), .DEPTH(DEPTH)) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_raddr (raddr),
            .o_rdata (rdata[b])
        );
    end

    assign src_rdata = rdata[r_src];

    // ---------------- shift line: tap 0 newest, centre at GM
    for (genvar t = 0; t < NTAP; t++) begin : g_cell
        if (t == 0) begin : g_head
            assign chain_in[t] = src_rdata;
        end else begin : g_link
            assign chain_in[t] = tap[t-1];
        end
        hds_cell #(.WIDTH(VB)) u_cell (
            .i_clk (i_clk),
            .i_en  (r_s1_vld),
            .i_d   (chain_in[t]),
            .o_q   (tap[t])
        );
    end

    assign interior = r_s2_vld && (r2_i >= 2) && (r2_i <= side_i - 1)
                      && (c2_i >= 1) && (c2_i <= side_i - 2);

    assign lap_c = LAP_W'($signed(tap[2*GM])) + LAP_W'($signed(tap[0]))
                 + LAP_W'($signed(tap[GM+1])) + LAP_W'($signed(tap[GM-1]))
                 - (LAP_W'($signed(tap[GM])) <<< 2);

    // saturate the product, floor to Q16.16, add and clamp
    always_comb begin
        p_sat = 128'(r_s4_prod);
        if (p_sat > P_MAX) p_sat = P_MAX;
        if (p_sat < P_MIN) p_sat = P_MIN;
        sum_w = 128'($signed(r_s4_old)) + (p_sat >>> 16);
        if (sum_w > V_MAX) sum_w = V_MAX;
        if (sum_w < V_MIN) sum_w = V_MIN;
        nv = sum_w[VB-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_s1_row  <= r_row;
        r_s1_col  <= r_col;
        r_s2_row  <= r_s1_row;
        r_s2_col  <= r_s1_col;
        r_s3_lap  <= lap_c;
        r_s3_old  <= tap[GM];
        r_s3_addr <= dst_addr;
        r_s4_prod <= PROD_W'(r_s3_lap) * PROD_W'($signed({1'b0, r_cfg_k}));
        r_s4_old  <= r_s3_old;
        r_s4_dold <= rdata[~r_src];
        r_s4_addr <= r_s3_addr;
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= interior;
            r_s4_vld <= r_s3_vld;
        end
    end

    // ---------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_inner <= INNER_RST;
            r_cfg_iter  <= ITER_RST;
            r_cfg_k     <= K_RST;
            r_cfg_top   <= TOP_RST;
            r_cfg_bot   <= BOT_RST;
            r_cfg_left  <= LEFT_RST;
            r_cfg_right <= RIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_INNER:  r_cfg_inner <= i_cfg_wdata[INNER_W-1:0];
                CFG_ITER:   r_cfg_iter  <= i_cfg_wdata[ITER_W-1:0];
                CFG_K:      r_cfg_k     <= i_cfg_wdata[K_W-1:0];
                CFG_TOP:    r_cfg_top   <= i_cfg_wdata;
                CFG_BOTTOM: r_cfg_bot   <= i_cfg_wdata;
                CFG_LEFT:   r_cfg_left  <= i_cfg_wdata;
                CFG_RIGHT:  r_cfg_right <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- control
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (t_func'(i_func) == FN_RUN) ? S_INIT : S_RDADDR;
                end
            end
            S_INIT: begin
                if (init_last) begin
                    n_state = (r_cfg_iter == '0) ? S_RESP : S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (sweep_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (pipe_empty) n_state = last_step ? S_RESP : S_SWEEP;
            end
            S_RDADDR: n_state = S_RESP;
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_bank   <= 1'b0;
            r_grid_valid <= 1'b0;
            r_src        <= 1'b0;
            r_changed    <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
            r_iter       <= '0;
            r_status     <= STS_RUN_DONE;
            r_rd_addr    <= '0;
        end else begin
            if (r_s4_vld && ((nv != r_s4_dold) || (nv != r_s4_old))) begin
                r_changed <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_row <= '0;
                        r_col <= '0;
                        if (t_func'(i_func) == FN_RUN) begin
                            r_status <= STS_RUN_DONE;
                        end else if ((32'(i_row_index) >= 32'(side))
                                     || (32'(i_col_index) >= 32'(side))) begin
                            r_status <= STS_READ_OOR;
                        end else begin
                            r_status  <= STS_READ_OK;
                            r_rd_addr <= f_addr(int'(i_row_index), int'(i_col_index));
                        end
                    end
                end
                S_INIT: begin
                    if (init_last) begin
                        r_row     <= '0;
                        r_col     <= '0;
                        r_src     <= 1'b0;
                        r_iter    <= '0;
                        r_changed <= 1'b0;
                        if (r_cfg_iter == '0) begin
                            r_cur_bank   <= 1'b0;
                            r_grid_valid <= 1'b1;
                        end
                    end else if (col_i == side_i - 1) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= r_col + RW'(1);
                    end
                end
                S_SWEEP: begin
                    if (col_i == GM - 1) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= r_col + RW'(1);
                    end
                end
                S_DRAIN: begin
                    if (pipe_empty) begin
                        // swap banks; the freshly written one becomes the source
                        r_src     <= ~r_src;
                        r_row     <= '0;
                        r_col     <= '0;
                        r_changed <= 1'b0;
                        r_iter    <= r_iter + ITER_W'(1);
                        if (last_step) begin
                            r_cur_bank   <= ~r_src;
                            r_grid_valid <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- result
    assign ov = 128'($signed(rdata[r_cur_bank]));

    always_comb begin
        o_busy       = (r_state != S_IDLE);
        o_valid      = (r_state == S_RESP);
        o_status     = r_status;
        o_cell_value = '0;
        if ((r_status == STS_READ_OK) && r_grid_valid) begin
            o_cell_value = ov[CELL_W-1:0];
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("request accepted but block not busy");

    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(o_busy) && !(o_status == STS_RUN_DONE && o_cell_value != '0)))
        else $error("bad result strobe");

    a_no_src_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld |-> (r_state == S_SWEEP || r_state == S_DRAIN))
        else $error("stencil write outside a sweep");

endmodule
